// ===== hw/rtl/hrhp_pkg.sv =====
// hrhp_pkg: character constants, byte classes and the result bundle
// of the http response head parser; no dependencies
package hrhp_pkg;

  localparam logic [7:0] CharH     = 8'h48;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharSp    = 8'h20;
  localparam logic [7:0] CharHt    = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDel   = 8'h7f;
  localparam logic [3:0] Ten       = 4'd10;

  typedef enum logic [1:0] {
    TagOther     = 2'd0,
    TagNameFirst = 2'd1,
    TagName      = 2'd2,
    TagValue     = 2'd3
  } byte_tag_e;

  typedef struct packed {
    logic [7:0] byte_out;
    byte_tag_e  byte_tag;
    logic [7:0] version_major;
    logic [7:0] version_minor;
    logic       version_valid;
    logic [9:0] status_code;
    logic       status_valid;
    logic       message_done;
    logic       parse_error;
  } result_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_ctl(logic [7:0] c);
    return (c < 8'h20) || (c == CharDel);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CharSp) || (c == CharHt);
  endfunction

  function automatic logic is_token(logic [7:0] c);
    logic sep;
    unique case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return !c[7] && !is_ctl(c) && !sep;
  endfunction

endpackage

// ===== hw/rtl/hrhp_fsm.sv =====
// hrhp_fsm: parse state, version and status accumulators, and the
// combinational result of one byte; depends on hrhp_pkg
module hrhp_fsm #(
  parameter int VERSION_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             req_i,
  input  logic [7:0]       byte_i,
  output hrhp_pkg::result_t res_o
);
  import hrhp_pkg::*;

  localparam int AccW = VERSION_BITS + 4;
  localparam int ExtW = VERSION_BITS + 8;
  localparam logic [VERSION_BITS-1:0] VerMax = {VERSION_BITS{1'b1}};

  typedef enum logic [4:0] {
    PhH, PhT1, PhT2, PhP, PhSlash, PhMaj0, PhMaj, PhMin0, PhMin,
    PhCode1, PhCode2, PhCode3, PhCodeSp, PhText, PhLf1, PhLine, PhFold,
    PhName, PhColSp, PhValue, PhLf2, PhLf3, PhDone, PhErr
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic                    seen_q, seen_d;
  logic [VERSION_BITS-1:0] major_q, major_d;
  logic [VERSION_BITS-1:0] minor_q, minor_d;
  logic [9:0]              code_q, code_d;
  logic                    ver_done_q, ver_done_d;
  logic                    code_done_q, code_done_d;
  byte_tag_e               tag;
  logic                    done;
  logic [ExtW-1:0]         major_ext, minor_ext;
  logic [13:0]             code_mul;

  function automatic logic [VERSION_BITS-1:0] ver_add(logic [VERSION_BITS-1:0] acc,
                                                      logic [7:0] c);
    logic [AccW-1:0] v;
    v = AccW'(acc) * AccW'(Ten) + AccW'(c - CharZero);
    return (v > AccW'(VerMax)) ? VerMax : v[VERSION_BITS-1:0];
  endfunction

  assign code_mul = 14'(code_q) * 14'(Ten) + 14'(byte_i[3:0]);

  always_comb begin
    phase_d     = PhErr;
    seen_d      = seen_q;
    major_d     = major_q;
    minor_d     = minor_q;
    code_d      = code_q;
    ver_done_d  = ver_done_q;
    code_done_d = code_done_q;
    tag         = TagOther;
    done        = 1'b0;
    unique case (phase_q)
      PhH:     if (byte_i == CharH) phase_d = PhT1;
      PhT1:    if (byte_i == CharT) phase_d = PhT2;
      PhT2:    if (byte_i == CharT) phase_d = PhP;
      PhP:     if (byte_i == CharP) phase_d = PhSlash;
      PhSlash: if (byte_i == CharSlash) phase_d = PhMaj0;
      PhMaj0: begin
        if (is_dig(byte_i)) begin
          major_d = ver_add(major_q, byte_i);
          phase_d = PhMaj;
        end
      end
      PhMaj: begin
        priority if (byte_i == CharDot) phase_d = PhMin0;
        else if (is_dig(byte_i)) begin
          major_d = ver_add(major_q, byte_i);
          phase_d = PhMaj;
        end
      end
      PhMin0: begin
        if (is_dig(byte_i)) begin
          minor_d = ver_add(minor_q, byte_i);
          phase_d = PhMin;
        end
      end
      PhMin: begin
        priority if (byte_i == CharSp) begin
          ver_done_d = 1'b1;
          phase_d    = PhCode1;
        end else if (is_dig(byte_i)) begin
          minor_d = ver_add(minor_q, byte_i);
          phase_d = PhMin;
        end
      end
      PhCode1, PhCode2, PhCode3: begin
        if (is_dig(byte_i)) begin
          code_d = code_mul[9:0];
          priority case (phase_q)
            PhCode1: phase_d = PhCode2;
            PhCode2: phase_d = PhCode3;
            default: begin
              code_done_d = 1'b1;
              phase_d     = PhCodeSp;
            end
          endcase
        end
      end
      PhCodeSp: if (byte_i == CharSp) phase_d = PhText;
      PhText: begin
        priority if (byte_i == CharCr) phase_d = PhLf1;
        else if (!is_ctl(byte_i)) phase_d = PhText;
      end
      PhLf1: if (byte_i == CharLf) phase_d = PhLine;
      PhLine: begin
        priority if (byte_i == CharCr) phase_d = PhLf3;
        else if (seen_q && is_blank(byte_i)) phase_d = PhFold;
        else if (is_token(byte_i)) begin
          seen_d  = 1'b1;
          tag     = TagNameFirst;
          phase_d = PhName;
        end
      end
      PhFold: begin
        priority if (byte_i == CharCr) phase_d = PhLf2;
        else if (is_blank(byte_i)) phase_d = PhFold;
        else if (!is_ctl(byte_i)) begin
          tag     = TagValue;
          phase_d = PhValue;
        end
      end
      PhName: begin
        priority if (byte_i == CharColon) phase_d = PhColSp;
        else if (is_token(byte_i)) begin
          tag     = TagName;
          phase_d = PhName;
        end
      end
      PhColSp: if (byte_i == CharSp) phase_d = PhValue;
      PhValue: begin
        priority if (byte_i == CharCr) phase_d = PhLf2;
        else if (!is_ctl(byte_i)) begin
          tag     = TagValue;
          phase_d = PhValue;
        end
      end
      PhLf2: if (byte_i == CharLf) phase_d = PhLine;
      PhLf3: begin
        if (byte_i == CharLf) begin
          done    = 1'b1;
          phase_d = PhDone;
        end
      end
      PhDone, PhErr: phase_d = PhErr;
      default:       phase_d = PhErr;
    endcase
  end

  assign major_ext = ExtW'(major_d);
  assign minor_ext = ExtW'(minor_d);

  always_comb begin
    if (req_i) begin
      res_o = '0;
    end else begin
      res_o.byte_out      = byte_i;
      res_o.byte_tag      = tag;
      res_o.version_major = major_ext[7:0];
      res_o.version_minor = minor_ext[7:0];
      res_o.version_valid = ver_done_d;
      res_o.status_code   = code_d;
      res_o.status_valid  = code_done_d;
      res_o.message_done  = done;
      res_o.parse_error   = (phase_d == PhErr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhH;
      seen_q      <= 1'b0;
      major_q     <= '0;
      minor_q     <= '0;
      code_q      <= '0;
      ver_done_q  <= 1'b0;
      code_done_q <= 1'b0;
    end else if (step_i) begin
      if (req_i) begin
        phase_q     <= PhH;
        seen_q      <= 1'b0;
        major_q     <= '0;
        minor_q     <= '0;
        code_q      <= '0;
        ver_done_q  <= 1'b0;
        code_done_q <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        seen_q      <= seen_d;
        major_q     <= major_d;
        minor_q     <= minor_d;
        code_q      <= code_d;
        ver_done_q  <= ver_done_d;
        code_done_q <= code_done_d;
      end
    end
  end

endmodule

// ===== hw/rtl/http_response_head_parser.sv =====
// http_response_head_parser: input register, parse step and result register
// depends on hrhp_pkg and hrhp_fsm
//
//   channel  handshake               payload
//   in       in_valid_i / in_ready_o  req_type_i, byte_in_i
//   out      out_valid_o / out_ready_i byte_out_o .. parse_error_o
//
// one byte per cycle sustained while the output is not stalled; a byte is held
// in the input register and its parse result is offered from the result register
// a restart is an ordinary byte transfer and gives an all-zero result
// rst_ni puts the parser back to expecting the start of the head
// a stalled output holds both stages; the input register refills as it drains
module http_response_head_parser #(
  parameter int VERSION_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic [1:0] byte_tag_o,
  output logic [7:0] version_major_o,
  output logic [7:0] version_minor_o,
  output logic       version_valid_o,
  output logic [9:0] status_code_o,
  output logic       status_valid_o,
  output logic       message_done_o,
  output logic       parse_error_o
);
  import hrhp_pkg::*;

  logic       in_valid_q;
  logic       req_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    res;
  result_t    res_q;
  logic       advance;
  logic       step;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  hrhp_fsm #(
    .VERSION_BITS(VERSION_BITS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_q),
    .byte_i (byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q  <= req_type_i;
      byte_q <= byte_in_i;
    end
    if (step) res_q <= res;
  end

  assign out_valid_o     = out_valid_q;
  assign byte_out_o      = res_q.byte_out;
  assign byte_tag_o      = res_q.byte_tag;
  assign version_major_o = res_q.version_major;
  assign version_minor_o = res_q.version_minor;
  assign version_valid_o = res_q.version_valid;
  assign status_code_o   = res_q.status_code;
  assign status_valid_o  = res_q.status_valid;
  assign message_done_o  = res_q.message_done;
  assign parse_error_o   = res_q.parse_error;

endmodule

// ===== tb/http_response_head_parser_test.sv =====
// http_response_head_parser_test: self-checking bench for the http response head parser
// drives byte transfers from a queue, predicts each result and checks the output stream
// depends on hrhp_pkg and http_response_head_parser
module http_response_head_parser_test;
  import hrhp_pkg::*;

  localparam int VersionBits   = 8;
  localparam int TotalItems    = 680;
  localparam int WatchdogLimit = 1500;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 8;

  typedef enum logic [4:0] {
    PhH, PhT1, PhT2, PhP, PhSlash, PhMaj0, PhMaj, PhMin0, PhMin,
    PhCode1, PhCode2, PhCode3, PhCodeSp, PhText, PhLf1, PhLine, PhFold,
    PhName, PhColSp, PhValue, PhLf2, PhLf3, PhDone, PhErr
  } phase_e;

  typedef struct {
    logic        req;
    logic [7:0]  data;
    int unsigned gap;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       req_type = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic [1:0] byte_tag;
  logic [7:0] version_major;
  logic [7:0] version_minor;
  logic       version_valid;
  logic [9:0] status_code;
  logic       status_valid;
  logic       message_done;
  logic       parse_error;

  http_response_head_parser #(
    .VERSION_BITS(VersionBits)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .byte_in_i      (byte_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .byte_out_o     (byte_out),
    .byte_tag_o     (byte_tag),
    .version_major_o(version_major),
    .version_minor_o(version_minor),
    .version_valid_o(version_valid),
    .status_code_o  (status_code),
    .status_valid_o (status_valid),
    .message_done_o (message_done),
    .parse_error_o  (parse_error)
  );

  always #4 clk = ~clk;

  // parser model state
  phase_e     phase;
  logic       seen_hdr;
  logic [7:0] major_acc;
  logic [7:0] minor_acc;
  logic [9:0] code_acc;
  logic       ver_seen;
  logic       code_seen;

  byte_item_t  pending_bytes[$];
  result_t     expected_results[$];
  logic [7:0]  head_bytes[$];
  result_t     want;

  int unsigned items_queued;
  int unsigned bytes_accepted;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned restarts;
  int unsigned heads_closed;
  int unsigned bad_heads;
  int unsigned quiet_cycles;
  int unsigned gap_count;
  int unsigned stall_left;
  int unsigned hold_left;
  logic        calm;
  logic        held;
  logic        in_taken;
  logic        out_taken;
  logic        nxt_valid;
  byte_item_t  cur_item;

  function automatic logic digit_byte(logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic logic ctl_byte(logic [7:0] c);
    return c < CharSp || c == CharDel;
  endfunction

  function automatic logic blank_byte(logic [7:0] c);
    return c == CharSp || c == CharHt;
  endfunction

  function automatic logic tok_byte(logic [7:0] c);
    logic sep;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
      "?", "=", "{", "}", CharSp, CharHt: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return !c[7] && !ctl_byte(c) && !sep;
  endfunction

  function automatic logic [7:0] sat_digit(logic [7:0] acc, logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - CharZero);
    return (v > (1 << VersionBits) - 1) ? 8'((1 << VersionBits) - 1) : v[7:0];
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(128, 255));
    else c = 8'($urandom_range(32, 126));
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CharZero + $urandom_range(0, 9));
  endfunction

  function automatic void add_head(logic [7:0] c);
    head_bytes = {head_bytes, c};
  endfunction

  function automatic void reset_parser();
    phase     = PhH;
    seen_hdr  = 1'b0;
    major_acc = '0;
    minor_acc = '0;
    code_acc  = '0;
    ver_seen  = 1'b0;
    code_seen = 1'b0;
  endfunction

  function automatic result_t parse_byte(logic req, logic [7:0] c);
    result_t     r;
    phase_e      nx;
    byte_tag_e   tag;
    logic        done;
    int unsigned acc;
    r = '0;
    if (req) begin
      reset_parser();
      return r;
    end
    nx   = PhErr;
    tag  = TagOther;
    done = 1'b0;
    case (phase)
      PhH:     if (c == CharH) nx = PhT1;
      PhT1:    if (c == CharT) nx = PhT2;
      PhT2:    if (c == CharT) nx = PhP;
      PhP:     if (c == CharP) nx = PhSlash;
      PhSlash: if (c == CharSlash) nx = PhMaj0;
      PhMaj0:  if (digit_byte(c)) begin
        major_acc = sat_digit(major_acc, c);
        nx = PhMaj;
      end
      PhMaj: begin
        if (c == CharDot) nx = PhMin0;
        else if (digit_byte(c)) begin
          major_acc = sat_digit(major_acc, c);
          nx = PhMaj;
        end
      end
      PhMin0: if (digit_byte(c)) begin
        minor_acc = sat_digit(minor_acc, c);
        nx = PhMin;
      end
      PhMin: begin
        if (c == CharSp) begin
          ver_seen = 1'b1;
          nx = PhCode1;
        end else if (digit_byte(c)) begin
          minor_acc = sat_digit(minor_acc, c);
          nx = PhMin;
        end
      end
      PhCode1, PhCode2, PhCode3: if (digit_byte(c)) begin
        acc = code_acc * 10 + (c - CharZero);
        code_acc = acc[9:0];
        if (phase == PhCode3) begin
          code_seen = 1'b1;
          nx = PhCodeSp;
        end else if (phase == PhCode2) nx = PhCode3;
        else nx = PhCode2;
      end
      PhCodeSp: if (c == CharSp) nx = PhText;
      PhText: begin
        if (c == CharCr) nx = PhLf1;
        else if (!ctl_byte(c)) nx = PhText;
      end
      PhLf1: if (c == CharLf) nx = PhLine;
      PhLine: begin
        if (c == CharCr) nx = PhLf3;
        else if (seen_hdr && blank_byte(c)) nx = PhFold;
        else if (tok_byte(c)) begin
          seen_hdr = 1'b1;
          tag = TagNameFirst;
          nx = PhName;
        end
      end
      PhFold: begin
        if (c == CharCr) nx = PhLf2;
        else if (blank_byte(c)) nx = PhFold;
        else if (!ctl_byte(c)) begin
          tag = TagValue;
          nx = PhValue;
        end
      end
      PhName: begin
        if (c == CharColon) nx = PhColSp;
        else if (tok_byte(c)) begin
          tag = TagName;
          nx = PhName;
        end
      end
      PhColSp: if (c == CharSp) nx = PhValue;
      PhValue: begin
        if (c == CharCr) nx = PhLf2;
        else if (!ctl_byte(c)) begin
          tag = TagValue;
          nx = PhValue;
        end
      end
      PhLf2: if (c == CharLf) nx = PhLine;
      PhLf3: if (c == CharLf) begin
        done = 1'b1;
        nx = PhDone;
      end
      default: nx = PhErr;
    endcase
    if (done) heads_closed++;
    if (nx == PhErr && phase != PhErr) bad_heads++;
    phase = nx;
    r.byte_out      = c;
    r.byte_tag      = tag;
    r.version_major = major_acc;
    r.version_minor = minor_acc;
    r.version_valid = ver_seen;
    r.status_code   = code_acc;
    r.status_valid  = code_seen;
    r.message_done  = done;
    r.parse_error   = (nx == PhErr);
    return r;
  endfunction

  task automatic push_byte(input logic req, input logic [7:0] data);
    byte_item_t it;
    it.req  = req;
    it.data = data;
    it.gap  = calm ? 0 : $urandom_range(0, 6);
    pending_bytes = {pending_bytes, it};
    items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(1'b0, s[i]);
  endtask

  task automatic push_crlf();
    push_byte(1'b0, CharCr);
    push_byte(1'b0, CharLf);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // sender: one item per transfer, random gap before each outside calm sequences
  always @(negedge clk) begin
    if (rst_n) begin
      nxt_valid = in_valid;
      if (in_taken) begin
        in_taken  = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_bytes.size() != 0) begin
        if (gap_count < pending_bytes[0].gap) gap_count++;
        else begin
          cur_item  = pending_bytes.pop_front();
          gap_count = 0;
          req_type  <= cur_item.req;
          byte_in   <= cur_item.data;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // receiver: random stall after each result except in every fourth run of 50 results, one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken  = 1'b0;
        stall_left = ((results_seen / 50) % 4 == 3) ? 0 : $urandom_range(0, 6);
        if (!held && results_seen >= 120) begin
          held      = 1'b1;
          hold_left = HoldCycles;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        expected_results = {expected_results, parse_byte(req_type, byte_in)};
        in_taken = 1'b1;
        bytes_accepted++;
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        results_seen++;
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected, byte_out %0d", byte_out);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(byte_out));
          check_field("byte_tag", 32'(want.byte_tag), 32'(byte_tag));
          check_field("version_major", 32'(want.version_major), 32'(version_major));
          check_field("version_minor", 32'(want.version_minor), 32'(version_minor));
          check_field("version_valid", 32'(want.version_valid), 32'(version_valid));
          check_field("status_code", 32'(want.status_code), 32'(status_code));
          check_field("status_valid", 32'(want.status_valid), 32'(status_valid));
          check_field("message_done", 32'(want.message_done), 32'(message_done));
          check_field("parse_error", 32'(want.parse_error), 32'(parse_error));
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned seq_no;
    logic [7:0]  c;
    items_queued   = 0;
    bytes_accepted = 0;
    results_seen   = 0;
    mismatches     = 0;
    restarts       = 0;
    heads_closed   = 0;
    bad_heads      = 0;
    quiet_cycles   = 0;
    gap_count      = 0;
    stall_left     = 0;
    hold_left      = 0;
    held           = 1'b0;
    in_taken       = 1'b0;
    out_taken      = 1'b0;
    calm           = 1'b0;
    reset_parser();

    // saturating major, empty status text, high byte in a value, folded line,
    // byte after done, restart, bad first byte
    push_text("HTTP/999.0 404 ");
    push_crlf();
    push_text("A: ");
    push_byte(1'b0, 8'hff);
    push_crlf();
    push_byte(1'b0, CharHt);
    push_text("z");
    push_crlf();
    push_crlf();
    push_byte(1'b0, CharH);
    push_byte(1'b1, 8'h5a);
    restarts++;
    push_text("X");

    seq_no = 0;
    while (items_queued < TotalItems) begin
      seq_no++;
      calm = (seq_no % 6 == 5);
      head_bytes.delete();
      if ($urandom_range(0, 9) != 0) begin
        push_byte(1'b1, 8'($urandom_range(0, 255)));
        restarts++;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 12)) add_head(8'($urandom_range(0, 255)));
      end else begin
        add_head(CharH);
        add_head(CharT);
        add_head(CharT);
        add_head(CharP);
        add_head(CharSlash);
        repeat ($urandom_range(1, 4)) add_head(rand_digit());
        add_head(CharDot);
        repeat ($urandom_range(1, 4)) add_head(rand_digit());
        add_head(CharSp);
        repeat (3) add_head(rand_digit());
        add_head(CharSp);
        repeat ($urandom_range(0, 5)) add_head(text_char());
        add_head(CharCr);
        add_head(CharLf);
        repeat ($urandom_range(0, 3)) begin
          repeat ($urandom_range(1, 4)) begin
            c = 8'($urandom_range(33, 126));
            while (!tok_byte(c)) c = 8'($urandom_range(33, 126));
            add_head(c);
          end
          add_head(CharColon);
          add_head(CharSp);
          repeat ($urandom_range(0, 5)) add_head(text_char());
          add_head(CharCr);
          add_head(CharLf);
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2))
              add_head($urandom_range(0, 1) ? CharSp : CharHt);
            repeat ($urandom_range(0, 4)) add_head(text_char());
            add_head(CharCr);
            add_head(CharLf);
          end
        end
        add_head(CharCr);
        add_head(CharLf);
        // corrupt one byte, or append stray bytes after the head
        if ($urandom_range(0, 3) == 0)
          head_bytes[$urandom_range(0, head_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) add_head(8'($urandom_range(0, 255)));
      end
      foreach (head_bytes[k]) push_byte(1'b0, head_bytes[k]);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (bytes_accepted < items_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end

    $display("run: %0d byte transfers in %0d sequences, %0d restarts, %0d results checked",
             bytes_accepted, seq_no, restarts, results_seen);
    $display("run: %0d heads completed, %0d grammar errors, %0d mismatches",
             heads_closed, bad_heads, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
